/* sv/bl_pkg.sv */
// shared types and constants for the bounded integer list
// no dependencies
package bl_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_APPEND   = 3'd1,
        OP_REM_HEAD = 3'd2,
        OP_REM_TAIL = 3'd3,
        OP_DELETE   = 3'd4,
        OP_QUERY    = 3'd5
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD
    } cell_act_t;

    typedef struct packed {
        cell_act_t act;
        logic      cmp_en;
        logic      occupied;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

endpackage

/* sv/bl_cell.sv */
// one list slot: holds an entry, shifts from either neighbor or loads the key, registers a key match
// depends on bl_pkg
module bl_cell (
    input  logic                       clk,
    input  bl_pkg::cell_ctrl_t         ctrl,
    input  logic [bl_pkg::DATA_W-1:0]  key,
    input  logic [bl_pkg::DATA_W-1:0]  left_data,
    input  logic [bl_pkg::DATA_W-1:0]  right_data,
    output logic [bl_pkg::DATA_W-1:0]  data,
    output logic                       match
);
    import bl_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic              match_reg, match_next;

    always_comb
    begin
        case (ctrl.act)
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            CELL_LOAD:  data_next = key;
            default:    data_next = data_reg;
        endcase
        match_next = ctrl.cmp_en ? (ctrl.occupied && (data_reg == key)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* sv/bounded_int_list_with_search_delete.sv */
// bounded list of signed 32-bit values held in a row of shifting cells
// a transaction passes through capture, compare pass and shift pass before its result is registered
// a new transaction is accepted only once the compare-then-shift pass over the cells has finished the last one
// the shift pass waits while the output register still holds an untaken result
// reset: rst_n asynchronous active low, list empty, no result pending; entries not cleared
// depends on bl_pkg and bl_cell
module bounded_int_list_with_search_delete #(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IN_TW   = ((bl_pkg::OP_W + bl_pkg::DATA_W + 7) / 8) * 8,
    localparam int OUT_W   = bl_pkg::DATA_W + 1 + bl_pkg::STATUS_W + CNT_W,
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // opcode, value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata    // removed_value, found, status, occupancy
);
    import bl_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OP_W-1:0]       op_reg;
    logic [DATA_W-1:0]     value_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic [DATA_W-1:0]     cell_data [CAPACITY];
    cell_ctrl_t            cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0]   m, first, ge, tail_sel;
    logic                  any, full, empty, fire, accept;
    logic [DATA_W-1:0]     tail_value, removed;
    logic                  found;
    logic [STATUS_W-1:0]   status;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign fire     = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign any      = |m;
    assign first    = m & (~m + CAPACITY'(1));
    assign ge       = ~(first - CAPACITY'(1));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d, right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = value_reg;
            end
            else
            begin : g_mid
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            assign tail_sel[gi] = (CNT_W'(gi + 1) == count_reg);

            always_comb
            begin
                cell_ctrl[gi].cmp_en   = (state_reg == S_CMP);
                cell_ctrl[gi].occupied = (CNT_W'(gi) < count_reg);
                cell_ctrl[gi].act      = CELL_HOLD;
                if (fire)
                begin
                    case (op_t'(op_reg))
                        OP_INS_HEAD: if (!full) cell_ctrl[gi].act = CELL_LEFT;
                        OP_APPEND:
                            if (!full && (CNT_W'(gi) == count_reg))
                                cell_ctrl[gi].act = CELL_LOAD;
                        OP_REM_HEAD: if (!empty) cell_ctrl[gi].act = CELL_RIGHT;
                        OP_DELETE:   if (any && ge[gi]) cell_ctrl[gi].act = CELL_RIGHT;
                        default:     cell_ctrl[gi].act = CELL_HOLD;
                    endcase
                end
            end

            bl_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .key        (value_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .match      (m[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
            tail_value = tail_value | (cell_data[i] & {DATA_W{tail_sel[i]}});
    end

    always_comb
    begin
        removed    = '0;
        found      = 1'b0;
        status     = ST_OK;
        count_next = count_reg;
        case (op_t'(op_reg))
            OP_INS_HEAD, OP_APPEND:
                if (full) status = ST_FULL;
                else      count_next = count_reg + CNT_W'(1);
            OP_REM_HEAD:
                if (empty) status = ST_EMPTY;
                else
                begin
                    removed    = cell_data[0];
                    count_next = count_reg - CNT_W'(1);
                end
            OP_REM_TAIL:
                if (empty) status = ST_EMPTY;
                else
                begin
                    removed    = tail_value;
                    count_next = count_reg - CNT_W'(1);
                end
            OP_DELETE:
                if (empty) status = ST_EMPTY;
                else if (any)
                begin
                    found      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            OP_QUERY: found = any;
            default:  found = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY:
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = {count_next, status, found, removed};
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tdata[OP_W-1:0];
            value_reg <= s_tdata[OP_W+DATA_W-1:OP_W];
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid && (state_reg == S_IDLE))
        else $error("shift pass did not post a result");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("entry count changed outside shift pass");

    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(first) && (any == (first != '0)))
        else $error("first match select not one-hot");

    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CMP))
        else $error("accepted transaction skipped compare pass");

endmodule
